// ===== hw/rtl/pwpi_pkg.sv =====
`default_nettype none

package pwpi_pkg;

    // field widths fixed by the stream format
    localparam int SAMPLE_BITS   = 12;
    localparam int ENERGY_BITS   = 16;
    localparam int PEAK_IDX_BITS = 5;
    localparam int DIFF_BITS     = SAMPLE_BITS + 1;

    // default for the waveform length limit
    localparam int MAX_SAMPLES_DEF = 32;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 12;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PED_SOURCE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PED_LEVEL  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIN_FIVE   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAT_THRESH = 3'd3;

    localparam logic [SAMPLE_BITS-1:0] SAT_THRESH_RESET = 12'd1000;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
    } t_in_item;

    typedef struct packed {
        logic signed [ENERGY_BITS-1:0] energy;
        logic [PEAK_IDX_BITS-1:0]      peak_index;
        logic [SAMPLE_BITS-1:0]        peak_value;
        logic [SAMPLE_BITS-1:0]        pedestal_used;
        logic                          saturated;
        logic                          too_long;
    } t_out_item;

    // window around the peak as seen at the end of a waveform
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] peak;
        logic [SAMPLE_BITS-1:0] ped;
        logic [SAMPLE_BITS-1:0] before0;
        logic [SAMPLE_BITS-1:0] before1;
        logic                   before0_ok;
        logic                   before1_ok;
        logic [SAMPLE_BITS-1:0] after0;
        logic [SAMPLE_BITS-1:0] after1;
        logic [1:0]             after_count;
        logic                   five;
    } t_window;

endpackage

`default_nettype wire

// ===== hw/rtl/pwpi_energy.sv =====
`default_nettype none

module pwpi_energy (
    input  wire pwpi_pkg::t_window                      i_win,
    output logic signed [pwpi_pkg::ENERGY_BITS-1:0]     o_energy
);

    localparam int EW = pwpi_pkg::ENERGY_BITS;
    localparam int DW = pwpi_pkg::DIFF_BITS;

    logic signed [DW-1:0] d_peak;
    logic signed [DW-1:0] d_b0;
    logic signed [DW-1:0] d_b1;
    logic signed [DW-1:0] d_a0;
    logic signed [DW-1:0] d_a1;
    logic signed [EW-1:0] t_b0;
    logic signed [EW-1:0] t_b1;
    logic signed [EW-1:0] t_a0;
    logic signed [EW-1:0] t_a1;

    // pedestal-subtracted terms
    assign d_peak = $signed({1'b0, i_win.peak})    - $signed({1'b0, i_win.ped});
    assign d_b0   = $signed({1'b0, i_win.before0}) - $signed({1'b0, i_win.ped});
    assign d_b1   = $signed({1'b0, i_win.before1}) - $signed({1'b0, i_win.ped});
    assign d_a0   = $signed({1'b0, i_win.after0})  - $signed({1'b0, i_win.ped});
    assign d_a1   = $signed({1'b0, i_win.after1})  - $signed({1'b0, i_win.ped});

    // only neighbours that exist inside the chosen window count
    always_comb begin
        t_b0 = '0;
        t_b1 = '0;
        t_a0 = '0;
        t_a1 = '0;
        if (i_win.before0_ok) begin
            t_b0 = EW'(d_b0);
        end
        if (i_win.after_count != 2'd0) begin
            t_a0 = EW'(d_a0);
        end
        if (i_win.five && i_win.before1_ok) begin
            t_b1 = EW'(d_b1);
        end
        if (i_win.five && (i_win.after_count == 2'd2)) begin
            t_a1 = EW'(d_a1);
        end
    end

    // five terms of 13 bits always fit the 16-bit result
    assign o_energy = EW'(d_peak) + t_b0 + t_b1 + t_a0 + t_a1;

endmodule

`default_nettype wire

// ===== hw/rtl/peak_window_pulse_integrator_unit.sv =====
`default_nettype none

// channel   direction  handshake                       payload
// in        input      i_in_valid / o_in_stall         i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_stall       o_out_data (t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// one sample is taken per cycle unless the input is stalled; the state update is a single compare and mux
// the result is registered at the transfer of the last sample, offered the next cycle
// synchronous active-low reset clears config, counters and flags
// input stalls only for a last sample while a result waits and out is stalled
// cfg writes are taken every cycle

module peak_window_pulse_integrator_unit #(
    parameter int MAX_SAMPLES = pwpi_pkg::MAX_SAMPLES_DEF
) (
    input  wire                                         i_clk,
    input  wire                                         i_rst_n,
    input  wire                                         i_in_valid,
    output logic                                        o_in_stall,
    input  wire pwpi_pkg::t_in_item                     i_in_data,
    output logic                                        o_out_valid,
    input  wire                                         i_out_stall,
    output pwpi_pkg::t_out_item                         o_out_data,
    input  wire                                         i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire [pwpi_pkg::CFG_INDEX_BITS-1:0]          i_cfg_index,
    input  wire [pwpi_pkg::CFG_DATA_BITS-1:0]           i_cfg_data
);

    localparam int SW    = pwpi_pkg::SAMPLE_BITS;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int POS_W = $clog2(MAX_SAMPLES);

    // configuration registers
    logic          r_ped_source;
    logic [SW-1:0] r_ped_level;
    logic          r_win_five;
    logic [SW-1:0] r_sat_thresh;

    // per-waveform state
    logic [CNT_W-1:0] r_count,   n_count;
    logic [SW-1:0]    r_max,     n_max;
    logic [POS_W-1:0] r_pos,     n_pos;
    logic [SW-1:0]    r_first,   n_first;
    logic [SW-1:0]    r_recent0, n_recent0;
    logic [SW-1:0]    r_recent1, n_recent1;
    logic [SW-1:0]    r_before0, n_before0;
    logic [SW-1:0]    r_before1, n_before1;
    logic             r_b0_ok,   n_b0_ok;
    logic             r_b1_ok,   n_b1_ok;
    logic [SW-1:0]    r_after0,  n_after0;
    logic [SW-1:0]    r_after1,  n_after1;
    logic [1:0]       r_acount,  n_acount;
    logic             r_sat,     n_sat;
    logic             r_ovf,     n_ovf;

    logic                r_out_valid;
    pwpi_pkg::t_out_item r_out;

    logic                in_xfer;
    logic [SW-1:0]       s;
    pwpi_pkg::t_window   win;
    logic signed [pwpi_pkg::ENERGY_BITS-1:0] energy;

    assign s           = i_in_data.sample;
    assign o_in_stall  = r_out_valid && i_out_stall && i_in_data.last;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ped_source <= 1'b0;
            r_ped_level  <= '0;
            r_win_five   <= 1'b0;
            r_sat_thresh <= pwpi_pkg::SAT_THRESH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pwpi_pkg::CFG_PED_SOURCE: r_ped_source <= i_cfg_data[0];
                pwpi_pkg::CFG_PED_LEVEL:  r_ped_level  <= SW'(i_cfg_data);
                pwpi_pkg::CFG_WIN_FIVE:   r_win_five   <= i_cfg_data[0];
                pwpi_pkg::CFG_SAT_THRESH: r_sat_thresh <= SW'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // next state for one sample
    always_comb begin
        n_count   = r_count;
        n_max     = r_max;
        n_pos     = r_pos;
        n_first   = r_first;
        n_recent0 = r_recent0;
        n_recent1 = r_recent1;
        n_before0 = r_before0;
        n_before1 = r_before1;
        n_b0_ok   = r_b0_ok;
        n_b1_ok   = r_b1_ok;
        n_after0  = r_after0;
        n_after1  = r_after1;
        n_acount  = r_acount;
        n_sat     = r_sat;
        n_ovf     = r_ovf;
        if (r_count < CNT_W'(MAX_SAMPLES)) begin
            if (s > r_sat_thresh) begin
                n_sat = 1'b1;
            end
            if (r_count == '0) begin
                // register mode keeps the level unless the sample beats it
                n_first  = s;
                n_max    = (r_ped_source && !(s > r_ped_level)) ? r_ped_level : s;
                n_pos    = '0;
                n_b0_ok  = 1'b0;
                n_b1_ok  = 1'b0;
                n_acount = 2'd0;
            end else if (s > r_max) begin
                // new peak takes the two preceding samples
                n_max     = s;
                n_pos     = r_count[POS_W-1:0];
                n_before0 = r_recent0;
                n_before1 = r_recent1;
                n_b0_ok   = 1'b1;
                n_b1_ok   = r_count > CNT_W'(1);
                n_acount  = 2'd0;
            end else if (r_acount == 2'd0) begin
                n_after0 = s;
                n_acount = 2'd1;
            end else if (r_acount == 2'd1) begin
                n_after1 = s;
                n_acount = 2'd2;
            end
            n_recent1 = r_recent0;
            n_recent0 = s;
            n_count   = r_count + CNT_W'(1);
        end else begin
            n_ovf = 1'b1;
        end
    end

    // window as it stands after the last sample
    always_comb begin
        win.peak        = n_max;
        win.ped         = r_ped_source ? r_ped_level : n_first;
        win.before0     = n_before0;
        win.before1     = n_before1;
        win.before0_ok  = n_b0_ok;
        win.before1_ok  = n_b1_ok;
        win.after0      = n_after0;
        win.after1      = n_after1;
        win.after_count = n_acount;
        win.five        = r_win_five;
    end

    pwpi_energy u_energy (
        .i_win    (win),
        .o_energy (energy)
    );

    // waveform state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_acount    <= 2'd0;
            r_b0_ok     <= 1'b0;
            r_b1_ok     <= 1'b0;
            r_sat       <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_xfer) begin
                r_max     <= n_max;
                r_pos     <= n_pos;
                r_first   <= n_first;
                r_recent0 <= n_recent0;
                r_recent1 <= n_recent1;
                r_before0 <= n_before0;
                r_before1 <= n_before1;
                r_after0  <= n_after0;
                r_after1  <= n_after1;
                if (i_in_data.last) begin
                    // emit result and start a fresh waveform
                    r_count     <= '0;
                    r_acount    <= 2'd0;
                    r_b0_ok     <= 1'b0;
                    r_b1_ok     <= 1'b0;
                    r_sat       <= 1'b0;
                    r_ovf       <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_out.energy        <= energy;
                    r_out.peak_index    <= pwpi_pkg::PEAK_IDX_BITS'(n_pos);
                    r_out.peak_value    <= n_max;
                    r_out.pedestal_used <= win.ped;
                    r_out.saturated     <= n_sat;
                    r_out.too_long      <= n_ovf;
                end else begin
                    r_count  <= n_count;
                    r_acount <= n_acount;
                    r_b0_ok  <= n_b0_ok;
                    r_b1_ok  <= n_b1_ok;
                    r_sat    <= n_sat;
                    r_ovf    <= n_ovf;
                end
            end
        end
    end

    // sample counter never passes the length limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("sample count above limit");

    // at most two after-peak samples are held
    a_after_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acount != 2'd3)
        else $error("after count out of range");

    // a last transfer clears the waveform and raises a result
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_data.last |=> r_count == '0 && !r_sat && !r_ovf && o_out_valid)
        else $error("waveform not closed after last sample");

    // a new result only follows a transfer of a last sample
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_xfer && i_in_data.last))
        else $error("result without last sample");

endmodule

`default_nettype wire
